>>> design/erx_pkg.sv
// Shared types, character codes and helpers for the escape-framed receive deframer.
package erx_pkg;

	localparam int LENGTH_DIGITS_DEF = 4;
	localparam int IP_CHARS_DEF      = 16;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam int CNT_W  = 14;
	localparam int PORT_W = 16;

	localparam logic [CNT_W-1:0]  LEN_MAX  = 14'h3fff;
	localparam logic [PORT_W-1:0] PORT_MAX = 16'hffff;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF_ = 8'h66;
	localparam logic [7:0] CH_H   = 8'h48;
	localparam logic [7:0] CH_U   = 8'h75;
	localparam logic [7:0] CH_Y   = 8'h79;
	localparam logic [7:0] CH_Z   = 8'h5a;
	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_O   = 8'h4f;
	localparam logic [7:0] CH_F   = 8'h46;
	localparam logic [7:0] CH_E   = 8'h45;

	localparam logic [3:0] KIND_LINE_START = 4'd0;
	localparam logic [3:0] KIND_LINE_BYTE  = 4'd1;
	localparam logic [3:0] KIND_LINE_END   = 4'd2;
	localparam logic [3:0] KIND_LINE_FLUSH = 4'd3;
	localparam logic [3:0] KIND_OK         = 4'd4;
	localparam logic [3:0] KIND_FAIL       = 4'd5;
	localparam logic [3:0] KIND_IP_CHAR    = 4'd6;
	localparam logic [3:0] KIND_IP_END     = 4'd7;
	localparam logic [3:0] KIND_PORT       = 4'd8;
	localparam logic [3:0] KIND_DATA       = 4'd9;
	localparam logic [3:0] KIND_DATA_END   = 4'd10;

	localparam logic [1:0] STEP_CONN = 2'd0;
	localparam logic [1:0] STEP_IP   = 2'd1;
	localparam logic [1:0] STEP_PORT = 2'd2;
	localparam logic [1:0] STEP_BODY = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
	} erx_in_t;

	typedef struct packed {
		logic [3:0]        kind;
		logic [3:0]        conn_id;
		logic [7:0]        out_byte;
		logic [3:0]        ip_index;
		logic [PORT_W-1:0] port_value;
		logic              last;
	} erx_out_t;

	// one queue entry: one or two results caused by a single input byte
	typedef struct packed {
		logic     dual;
		erx_out_t res0;
		erx_out_t res1;
	} erx_cmd_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if ((c >= CH_0) && (c <= CH_9)) begin
			t = c - CH_0;
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			t = c - CH_UA + 8'd10;
		end else if ((c >= CH_LA) && (c <= CH_LF_)) begin
			t = c - CH_LA + 8'd10;
		end
		return t[3:0];
	endfunction

endpackage

>>> design/erx_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface erx_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/erx_front.sv
// Front end: accepts received bytes, runs the frame parser and queues result commands.
module erx_front #(
	parameter int LENGTH_DIGITS = erx_pkg::LENGTH_DIGITS_DEF,
	parameter int IP_CHARS      = erx_pkg::IP_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	erx_stream_if.sink        in_ch,
	input  logic              q_full,
	output logic              push,
	output erx_pkg::erx_cmd_t push_cmd
);
	import erx_pkg::*;

	typedef enum logic [8:0] {
		MODE_CMD      = 9'b000000001,
		MODE_LINE     = 9'b000000010,
		MODE_ESC      = 9'b000000100,
		MODE_ASC_S    = 9'b000001000,
		MODE_ASC_U    = 9'b000010000,
		MODE_BLK_Z    = 9'b000100000,
		MODE_BLK_Y    = 9'b001000000,
		MODE_BLK_H    = 9'b010000000,
		MODE_BLK_DATA = 9'b100000000
	} erx_mode_t;

	localparam logic [CNT_W-1:0] IP_LIM  = CNT_W'(IP_CHARS - 1);
	localparam logic [CNT_W-1:0] LEN_DIG = CNT_W'(LENGTH_DIGITS);

	erx_mode_t         mode_q, mode_d;
	logic [1:0]        step_q, step_d;
	logic [3:0]        conn_q, conn_d;
	logic [CNT_W-1:0]  len_q, len_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              esc_q, esc_d;
	logic [PORT_W-1:0] port_q, port_d;

	logic              accept;
	logic              emit;
	logic              do_hdr;
	logic [7:0]        c;
	logic [3:0]        dig;
	logic [19:0]       port_mul;
	logic [17:0]       len_mul;
	logic [CNT_W-1:0]  cnt_inc;
	erx_cmd_t          cmd;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.data.rx_byte;
	assign dig         = is_digit(c) ? 4'(c - CH_0) : 4'd0;
	assign port_mul    = {4'b0, port_q} * 20'd10 + {16'b0, dig};
	assign len_mul     = {4'b0, len_q} * 18'd10 + {14'b0, dig};
	assign cnt_inc     = cnt_q + 14'd1;

	always_comb begin
		mode_d = mode_q;
		step_d = step_q;
		conn_d = conn_q;
		len_d  = len_q;
		cnt_d  = cnt_q;
		esc_d  = esc_q;
		port_d = port_q;
		emit   = 1'b0;
		do_hdr = 1'b0;
		cmd    = '0;
		cmd.res0.conn_id = conn_q;
		cmd.res1.conn_id = conn_q;

		case (mode_q)
			MODE_LINE: begin
				if (c != CH_NUL) begin
					if ((c == CH_LF) || (c == CH_CR)) begin
						cmd.res0.kind    = KIND_LINE_END;
						cmd.res0.conn_id = 4'd0;
						emit   = 1'b1;
						mode_d = MODE_CMD;
					end else if (c == CH_ESC) begin
						mode_d = MODE_ESC;
					end else begin
						cmd.res0.kind     = KIND_LINE_BYTE;
						cmd.res0.conn_id  = 4'd0;
						cmd.res0.out_byte = c;
						emit = 1'b1;
					end
				end
			end
			MODE_ESC: begin
				step_d = STEP_CONN;
				mode_d = MODE_CMD;
				case (c)
					CH_H: mode_d = MODE_BLK_H;
					CH_U: mode_d = MODE_ASC_U;
					CH_Y: mode_d = MODE_BLK_Y;
					CH_Z: mode_d = MODE_BLK_Z;
					CH_S: mode_d = MODE_ASC_S;
					CH_O: begin
						cmd.res0.kind    = KIND_OK;
						cmd.res0.conn_id = 4'd0;
						emit = 1'b1;
					end
					CH_F: begin
						cmd.res0.kind    = KIND_FAIL;
						cmd.res0.conn_id = 4'd0;
						emit = 1'b1;
					end
					default: mode_d = MODE_CMD;
				endcase
			end
			MODE_ASC_S, MODE_ASC_U: begin
				if (step_q == STEP_CONN) begin
					conn_d = hex_val(c);
					cnt_d  = '0;
					step_d = (mode_q == MODE_ASC_S) ? STEP_BODY : STEP_IP;
				end else if (step_q != STEP_BODY) begin
					do_hdr = 1'b1;
				end else if (esc_q) begin
					esc_d = 1'b0;
					emit  = 1'b1;
					if (c == CH_E) begin
						cmd.res0.kind = KIND_DATA_END;
						mode_d = MODE_CMD;
					end else begin
						cmd.dual          = 1'b1;
						cmd.res0.kind     = KIND_DATA;
						cmd.res0.out_byte = CH_ESC;
						cmd.res1.kind     = KIND_DATA;
						cmd.res1.out_byte = c;
					end
				end else if (c == CH_ESC) begin
					esc_d = 1'b1;
				end else begin
					cmd.res0.kind     = KIND_DATA;
					cmd.res0.out_byte = c;
					emit = 1'b1;
				end
			end
			MODE_BLK_Z, MODE_BLK_Y, MODE_BLK_H: begin
				if (step_q == STEP_CONN) begin
					conn_d = hex_val(c);
					len_d  = '0;
					cnt_d  = '0;
					step_d = (mode_q == MODE_BLK_Y) ? STEP_IP : STEP_BODY;
				end else if (step_q != STEP_BODY) begin
					do_hdr = 1'b1;
				end else begin
					len_d = (len_mul > {4'b0, LEN_MAX}) ? LEN_MAX : len_mul[CNT_W-1:0];
					if (cnt_inc >= LEN_DIG) begin
						cnt_d  = '0;
						mode_d = MODE_BLK_DATA;
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			MODE_BLK_DATA: begin
				cmd.res0.kind     = KIND_DATA;
				cmd.res0.out_byte = c;
				emit  = 1'b1;
				cnt_d = (cnt_q < LEN_MAX) ? cnt_inc : cnt_q;
				if (cnt_d >= len_q) begin
					cmd.dual      = 1'b1;
					cmd.res1.kind = KIND_DATA_END;
					mode_d = MODE_CMD;
				end
			end
			default: begin
				if ((c != CH_NUL) && (c != CH_LF) && (c != CH_CR)) begin
					emit = 1'b1;
					cmd.res0.conn_id = 4'd0;
					if (c == CH_ESC) begin
						cmd.res0.kind = KIND_LINE_FLUSH;
						mode_d = MODE_ESC;
					end else begin
						cmd.res0.kind     = KIND_LINE_START;
						cmd.res0.out_byte = c;
						mode_d = MODE_LINE;
					end
				end
			end
		endcase

		// shared header fields: ip string, then decimal port
		if (do_hdr) begin
			if (step_q == STEP_IP) begin
				if (is_digit(c) || (c == CH_DOT)) begin
					if (cnt_q < IP_LIM) begin
						cmd.res0.kind     = KIND_IP_CHAR;
						cmd.res0.out_byte = c;
						cmd.res0.ip_index = cnt_q[3:0];
						emit  = 1'b1;
						cnt_d = cnt_inc;
					end
				end else begin
					cmd.res0.kind     = KIND_IP_END;
					cmd.res0.ip_index = (cnt_q < IP_LIM) ? cnt_q[3:0] : IP_LIM[3:0];
					emit   = 1'b1;
					port_d = '0;
					step_d = STEP_PORT;
				end
			end else if (is_digit(c)) begin
				port_d = (port_mul > {4'b0, PORT_MAX}) ? PORT_MAX : port_mul[PORT_W-1:0];
			end else begin
				cmd.res0.kind       = KIND_PORT;
				cmd.res0.port_value = port_q;
				emit   = 1'b1;
				step_d = STEP_BODY;
				cnt_d  = '0;
			end
		end

		cmd.res0.last = !cmd.dual;
		cmd.res1.last = 1'b1;
	end

	assign push     = accept && emit;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CMD;
			step_q <= STEP_CONN;
			conn_q <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
			esc_q  <= 1'b0;
			port_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			step_q <= step_d;
			conn_q <= conn_d;
			len_q  <= len_d;
			cnt_q  <= cnt_d;
			esc_q  <= esc_d;
			port_q <= port_d;
		end
	end

	a_esc_only_in_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> ((mode_q == MODE_ASC_S) || (mode_q == MODE_ASC_U)) && (step_q == STEP_BODY))
		else $error("escape pending outside ascii payload");

endmodule

>>> design/erx_queue.sv
// Short command queue between the parser and the result emitter.
module erx_queue #(
	parameter int DEPTH = erx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  erx_pkg::erx_cmd_t push_cmd,
	output logic              full,
	output logic              head_valid,
	output erx_pkg::erx_cmd_t head_cmd,
	input  logic              pop
);
	import erx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	erx_cmd_t       mem_q [DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

>>> design/erx_back.sv
// Back end: emits queued commands one result per transfer through an output register.
module erx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  erx_pkg::erx_cmd_t head_cmd,
	output logic              pop,
	erx_stream_if.source      out_ch
);
	import erx_pkg::*;

	logic     out_valid_q;
	erx_out_t out_q;
	logic     half_q;
	logic     load;

	assign load = !out_valid_q || out_ch.ready;
	assign pop  = load && head_valid && (!head_cmd.dual || half_q);

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= half_q ? head_cmd.res1 : head_cmd.res0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				half_q <= head_cmd.dual && !half_q;
			end
		end
	end

	a_half_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> head_valid && head_cmd.dual)
		else $error("second result pending without a paired entry");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ch.ready && !out_q.last |=> out_valid_q && out_q.last)
		else $error("first result of a pair not followed by its partner");

endmodule

>>> design/escape_framed_rx_deframer.sv
// Top level of the escape-framed receive deframer.
//   channel  dir  payload                                              transfer when
//   in_ch    in   rx_byte                                              valid && ready
//   out_ch   out  kind, conn_id, out_byte, ip_index, port_value, last  valid && ready
// One byte is accepted per cycle while the queue is not full; the parser updates all frame state in that cycle.
// Each accepted byte yields zero, one or two results; a pair leaves as separate output transfers, res0 first.
// An accepted byte's first result passes through the queue and then the output register.
// in_ch.ready drops only when the command queue (QUEUE_DEPTH entries) is full.
// arst_n clears parser state, queue pointers and the output valid; no clearing pass.
module escape_framed_rx_deframer #(
	parameter int LENGTH_DIGITS = erx_pkg::LENGTH_DIGITS_DEF,
	parameter int IP_CHARS      = erx_pkg::IP_CHARS_DEF,
	parameter int QUEUE_DEPTH   = erx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	erx_stream_if.sink   in_ch,
	erx_stream_if.source out_ch
);
	import erx_pkg::*;

	logic     push;
	erx_cmd_t push_cmd;
	logic     q_full;
	logic     head_valid;
	erx_cmd_t head_cmd;
	logic     pop;

	erx_front #(
		.LENGTH_DIGITS(LENGTH_DIGITS),
		.IP_CHARS     (IP_CHARS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	erx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop)
	);

	erx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
